// File: hdl/wcsd_pkg.sv
package wcsd_pkg;

  // Table and token geometry.
  localparam int WORD_CAPACITY = 1024;
  localparam int TOKEN_BYTES   = 32;
  localparam int KEEP_MAX      = TOKEN_BYTES - 1;
  localparam int POS_W         = $clog2(WORD_CAPACITY);
  localparam int ENT_W         = $clog2(WORD_CAPACITY + 1);
  localparam int LEN_W         = $clog2(TOKEN_BYTES);
  localparam int CNT_W         = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Kind codes.
  localparam logic KIND_LEARN = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef logic [KEEP_MAX-1:0][7:0] word_t;

  // Control that the sequencer broadcasts to every cell.
  typedef struct packed {
    logic cmp_en;
    logic upd_en;
    logic learn;
    logic insert;
  } cell_ctl_t;

endpackage

// File: hdl/wcsd_tokenizer.sv
module wcsd_tokenizer (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      byte_en,
  input  logic [7:0]                text_byte,
  input  logic                      end_of_text,
  input  logic                      clear,
  output logic                      word_done,
  output wcsd_pkg::word_t           tok_word,
  output logic [wcsd_pkg::LEN_W-1:0] tok_len
);

  wcsd_pkg::word_t                 buf_r;
  logic [wcsd_pkg::LEN_W-1:0]      len_r;
  logic [wcsd_pkg::LEN_W-1:0]      len_nxt;
  logic                            is_brk;
  logic                            append;
  logic [7:0]                      low_byte;

  // Separator detection and A-Z folding.
  always_comb begin
    is_brk = (text_byte == 8'h20) || (text_byte == 8'h09) || (text_byte == 8'h0A) ||
             (text_byte == 8'h0D) || (text_byte == 8'h2C) || (text_byte == 8'h2E) ||
             (text_byte == 8'h3B) || (text_byte == 8'h28) || (text_byte == 8'h29);
    low_byte = ((text_byte >= 8'h41) && (text_byte <= 8'h5A)) ? (text_byte + 8'h20)
                                                               : text_byte;
    append = byte_en && !is_brk && (len_r < wcsd_pkg::LEN_W'(wcsd_pkg::KEEP_MAX));
    len_nxt = append ? (len_r + wcsd_pkg::LEN_W'(1)) : len_r;
    if (is_brk) begin
      word_done = byte_en && (len_r != '0);
    end else begin
      word_done = byte_en && end_of_text && (len_nxt != '0);
    end
  end

  // The word stays held until the table update has used it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (clear) begin
      len_r <= '0;
    end else begin
      len_r <= len_nxt;
    end
    if (append) begin
      buf_r[len_r] <= low_byte;
    end
  end

  assign tok_word = buf_r;
  assign tok_len  = len_r;

endmodule

// File: hdl/wcsd_cell.sv
module wcsd_cell (
  input  logic                        clk,
  input  logic [wcsd_pkg::POS_W-1:0]  idx,
  input  logic [wcsd_pkg::ENT_W-1:0]  entries,
  input  wcsd_pkg::cell_ctl_t         ctl,
  input  wcsd_pkg::word_t             tok_word,
  input  logic [wcsd_pkg::LEN_W-1:0]  tok_len,
  input  logic                        prev_lt,
  input  wcsd_pkg::word_t             prev_word,
  input  logic [wcsd_pkg::LEN_W-1:0]  prev_len,
  input  logic [wcsd_pkg::CNT_W-1:0]  prev_cnt,
  output logic                        lt,
  output logic                        eq,
  output wcsd_pkg::word_t             word,
  output logic [wcsd_pkg::LEN_W-1:0]  len,
  output logic [wcsd_pkg::CNT_W-1:0]  cnt,
  output logic [wcsd_pkg::CNT_W-1:0]  hit_cnt
);

  wcsd_pkg::word_t                 word_r;
  logic [wcsd_pkg::LEN_W-1:0]      len_r;
  logic [wcsd_pkg::CNT_W-1:0]      cnt_r;
  logic                            lt_r;
  logic                            eq_r;
  logic                            valid;
  logic [wcsd_pkg::KEEP_MAX-1:0]   k_eq;
  logic [wcsd_pkg::KEEP_MAX-1:0]   k_lt;
  logic [wcsd_pkg::KEEP_MAX-1:0]   pre_eq;
  logic                            lt_c;
  logic [wcsd_pkg::CNT_W-1:0]      cnt_up;

  // Per-byte keys: a byte past the end sorts below any kept byte.
  always_comb begin
    valid = {1'b0, idx} < entries;
    for (int i = 0; i < wcsd_pkg::KEEP_MAX; i++) begin
      logic       va;
      logic       vb;
      logic [8:0] ka;
      logic [8:0] kb;
      va = wcsd_pkg::LEN_W'(i) < len_r;
      vb = wcsd_pkg::LEN_W'(i) < tok_len;
      ka = va ? {1'b1, word_r[i]} : 9'd0;
      kb = vb ? {1'b1, tok_word[i]} : 9'd0;
      k_eq[i] = (ka == kb);
      k_lt[i] = (ka < kb);
    end
    pre_eq[0] = 1'b1;
    for (int i = 1; i < wcsd_pkg::KEEP_MAX; i++) begin
      pre_eq[i] = pre_eq[i-1] & k_eq[i-1];
    end
    lt_c = |(k_lt & pre_eq);
  end

  // Update path: shift from the left neighbor, take the new word, or count.
  always_comb begin
    cnt_up = (ctl.learn && (cnt_r != wcsd_pkg::CNT_MAX)) ? (cnt_r + wcsd_pkg::CNT_W'(1))
                                                         : cnt_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      lt_r <= valid & lt_c;
      eq_r <= valid & (&k_eq);
    end
    if (ctl.upd_en) begin
      if (ctl.insert) begin
        if (!prev_lt) begin
          word_r <= prev_word;
          len_r  <= prev_len;
          cnt_r  <= prev_cnt;
        end else if (!lt_r) begin
          word_r <= tok_word;
          len_r  <= tok_len;
          cnt_r  <= wcsd_pkg::CNT_W'(1);
        end
      end else if (eq_r) begin
        cnt_r <= cnt_up;
      end
    end
  end

  assign lt      = lt_r;
  assign eq      = eq_r;
  assign word    = word_r;
  assign len     = len_r;
  assign cnt     = cnt_r;
  assign hit_cnt = eq_r ? cnt_up : '0;

endmodule

// File: hdl/word_count_sorted_dictionary_unit.sv
// Word frequency counter over a sorted dictionary held in a chain of cells.
// Input channel: one text byte per transaction on in_tdata; in_tuser is the
// kind (0 learn, 1 query), in_tlast marks end of text and flushes the word.
// Bytes that do not finish a word are accepted back to back while idle. A byte
// that finishes a word passes through acceptance, a compare step in which every
// cell compares its stored word with the token, and an update step in which, on
// a learn, the cells from the slot on shift right by one to insert a new word (or
// a stored word's count is bumped), and the result is registered for output.
// Output channel: one transaction per finished word; out_tuser is the kind.
// The block takes no byte while a word is in the compare or update cycle;
// if an earlier result still waits on the output with out_tready low, the update waits.
// Reset (rst_n low, synchronous) empties the table and drops any partial
// word; the cell storage itself is not cleared, since only cells below the
// entry count are ever compared.
module word_count_sorted_dictionary_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,  // [7:0] text_byte
  input  logic        in_tuser,  // [0] kind
  input  logic        in_tlast,  // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata, // [0] found, [10:1] position, [42:11] occurrence_count,
                                 // [47:43] word_length, [48] table_full,
                                 // [59:49] entries_now, [63:60] zero
  output logic        out_tuser  // [0] word_kind
);

  localparam int N = wcsd_pkg::WORD_CAPACITY;

  typedef enum logic [1:0] {ST_IDLE, ST_CMP, ST_UPD} state_t;

  state_t                              state_r;
  logic                                kind_r;
  logic [wcsd_pkg::ENT_W-1:0]          entries_r;
  logic                                out_tvalid_r;
  logic [63:0]                         out_tdata_r;
  logic                                out_tuser_r;

  logic                                in_fire;
  logic                                word_done;
  logic                                upd_fire;
  wcsd_pkg::word_t                     tok_word;
  logic [wcsd_pkg::LEN_W-1:0]          tok_len;
  wcsd_pkg::cell_ctl_t                 ctl;

  logic [N-1:0]                        lt_v;
  logic [N-1:0]                        eq_v;
  logic [N-1:0]                        bnd_v;
  wcsd_pkg::word_t                     word_v [N];
  logic [wcsd_pkg::LEN_W-1:0]          len_v [N];
  logic [wcsd_pkg::CNT_W-1:0]          cnt_v [N];
  logic [wcsd_pkg::CNT_W-1:0]          hit_v [N];

  logic                                found;
  logic                                full;
  logic                                insert;
  logic [wcsd_pkg::POS_W-1:0]          pos;
  logic [wcsd_pkg::CNT_W-1:0]          hit_cnt;
  logic [wcsd_pkg::ENT_W-1:0]          entries_nxt;
  logic [wcsd_pkg::CNT_W-1:0]          count_out;
  logic [wcsd_pkg::POS_W-1:0]          pos_out;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign upd_fire  = (state_r == ST_UPD) && (!out_tvalid_r || out_tready);

  wcsd_tokenizer u_tok (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_en     (in_fire),
    .text_byte   (in_tdata),
    .end_of_text (in_tlast),
    .clear       (upd_fire),
    .word_done   (word_done),
    .tok_word    (tok_word),
    .tok_len     (tok_len)
  );

  // Lookup outcome from the registered compare flags of all cells.
  always_comb begin
    found   = |eq_v;
    pos     = '0;
    hit_cnt = '0;
    bnd_v   = ~lt_v & {lt_v[N-2:0], 1'b1};
    for (int i = 0; i < N; i++) begin
      if (bnd_v[i]) begin
        pos = pos | wcsd_pkg::POS_W'(i);
      end
      hit_cnt = hit_cnt | hit_v[i];
    end
    full   = (kind_r == wcsd_pkg::KIND_LEARN) && !found &&
             (entries_r == wcsd_pkg::ENT_W'(N));
    insert = (kind_r == wcsd_pkg::KIND_LEARN) && !found && !full;
    entries_nxt = insert ? (entries_r + wcsd_pkg::ENT_W'(1)) : entries_r;
    if (found) begin
      count_out = hit_cnt;
      pos_out   = pos;
    end else if (insert) begin
      count_out = wcsd_pkg::CNT_W'(1);
      pos_out   = pos;
    end else begin
      count_out = '0;
      pos_out   = '0;
    end
    ctl.cmp_en = (state_r == ST_CMP);
    ctl.upd_en = upd_fire;
    ctl.learn  = (kind_r == wcsd_pkg::KIND_LEARN);
    ctl.insert = insert;
  end

  // The chain: each cell sees its left neighbor's flag and contents; the first sees the token.
  for (genvar g = 0; g < N; g++) begin : g_cell
    logic                          p_lt;
    wcsd_pkg::word_t               p_word;
    logic [wcsd_pkg::LEN_W-1:0]    p_len;
    logic [wcsd_pkg::CNT_W-1:0]    p_cnt;
    if (g == 0) begin : g_head
      assign p_lt   = 1'b1;
      assign p_word = tok_word;
      assign p_len  = tok_len;
      assign p_cnt  = '0;
    end else begin : g_body
      assign p_lt   = lt_v[g-1];
      assign p_word = word_v[g-1];
      assign p_len  = len_v[g-1];
      assign p_cnt  = cnt_v[g-1];
    end
    wcsd_cell u_cell (
      .clk       (clk),
      .idx       (wcsd_pkg::POS_W'(g)),
      .entries   (entries_r),
      .ctl       (ctl),
      .tok_word  (tok_word),
      .tok_len   (tok_len),
      .prev_lt   (p_lt),
      .prev_word (p_word),
      .prev_len  (p_len),
      .prev_cnt  (p_cnt),
      .lt        (lt_v[g]),
      .eq        (eq_v[g]),
      .word      (word_v[g]),
      .len       (len_v[g]),
      .cnt       (cnt_v[g]),
      .hit_cnt   (hit_v[g])
    );
  end

  // Sequencer, entry count and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      entries_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire && word_done) begin
            state_r <= ST_CMP;
            kind_r  <= in_tuser;
          end
        end
        ST_CMP: begin
          state_r <= ST_UPD;
        end
        ST_UPD: begin
          if (upd_fire) begin
            state_r      <= ST_IDLE;
            entries_r    <= entries_nxt;
            out_tvalid_r <= 1'b1;
            out_tuser_r  <= kind_r;
            out_tdata_r  <= {4'd0, entries_nxt, full, tok_len, count_out, pos_out, found};
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // At most one cell can match the token.
  a_eq_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |-> $onehot0(eq_v))
    else $error("more than one cell matched the token");

  // The table never holds more words than cells.
  a_entries_cap: assert property (@(posedge clk) disable iff (!rst_n)
    entries_r <= wcsd_pkg::ENT_W'(N))
    else $error("entry count beyond capacity");

  // A byte that finished a word is followed by a compare cycle.
  a_cmp_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && word_done) |=> (state_r == ST_CMP))
    else $error("finished word did not start a compare");

  // The entry count changes only in an update, where it moves by at most one.
  a_entries_step: assert property (@(posedge clk) disable iff (!rst_n)
    !upd_fire |=> $stable(entries_r))
    else $error("entry count changed outside an update");

endmodule
